// ===== src/rlt_pkg.sv =====
// Shared widths, codes and types for the range lock table.
package rlt_pkg;

	// Default number of table entries.
	localparam int ENTRIES_DEF = 16;

	// Field widths.
	localparam int ACT_W = 2;
	localparam int OFS_W = 48;
	localparam int LEN_W = 32;
	localparam int END_W = OFS_W + 1;
	localparam int STS_W = 2;

	// Action codes carried by an input word.
	typedef enum logic [ACT_W-1:0] {
		ACT_ADD   = 2'd0,
		ACT_DEL   = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Status codes returned in a result word.
	typedef enum logic [STS_W-1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_RSVD      = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Outcome of comparing one stored entry with the request range.
	typedef struct packed {
		logic exact;
		logic overlap;
	} cmp_res_t;

endpackage

// ===== src/range_lock_table.sv =====
// Range lock table top level: request sequencer, entry store and compare unit.
//
// Channel   Direction  Handshake             Fields
// request   in         req_valid/req_stall   action, offset, length
// response  out        rsp_valid/rsp_stall   locked, status
//
// A response follows the scan of the entries, with no scan at all for the
// unused action. The next request can be accepted only once the response
// is taken and the sequencer has returned to idle.
// The sequencer walks the entries one per cycle through the single read port
// of the entry store and stops at the first entry that decides the result.
// Reset clears all valid flags at once; no clearing pass is needed.
// The request side is stalled from acceptance until the response is taken.
// A stalled response holds its value.
module range_lock_table #(
	parameter int ENTRIES = rlt_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [rlt_pkg::ACT_W-1:0] action,
	input  logic [rlt_pkg::OFS_W-1:0] offset,
	input  logic [rlt_pkg::LEN_W-1:0] length,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic                      locked,
	output logic [rlt_pkg::STS_W-1:0] status
);
	import rlt_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	state_t state_q;
	action_t act_q;
	logic [OFS_W-1:0] lo_q;
	logic [END_W-1:0] hi_q;
	logic [CW-1:0] idx_q;
	logic pv_s1;
	logic [IW-1:0] ridx_s1;
	logic locked_q;
	status_t status_q;

	logic rd_en;
	logic rd_valid;
	logic [OFS_W-1:0] rd_start;
	logic [END_W-1:0] rd_end;
	cmp_res_t cmp;
	logic hit;
	logic last;
	logic finish;
	logic wr_en;
	logic wr_set;
	logic accept;

	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = (state_q == ST_DONE);
	assign locked = locked_q;
	assign status = status_q;

	// Issue one read per cycle while entries remain.
	assign rd_en = (state_q == ST_SCAN) && (idx_q < CW'(ENTRIES));

	rlt_mem #(
		.ENTRIES(ENTRIES),
		.IW(IW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(idx_q[IW-1:0]),
		.wr_en(wr_en),
		.wr_set(wr_set),
		.wr_addr(ridx_s1),
		.wr_start(lo_q),
		.wr_end(hi_q),
		.rd_valid_q(rd_valid),
		.rd_start_q(rd_start),
		.rd_end_q(rd_end)
	);

	rlt_cmp u_cmp (
		.ent_start(rd_start),
		.ent_end(rd_end),
		.lo(lo_q),
		.hi(hi_q),
		.res(cmp)
	);

	// Decide whether the entry just read ends the scan.
	always_comb begin
		case (act_q)
			ACT_ADD:   hit = !rd_valid;
			ACT_DEL:   hit = rd_valid && cmp.exact;
			ACT_QUERY: hit = rd_valid && cmp.overlap;
			default:   hit = 1'b0;
		endcase
	end

	assign last = (ridx_s1 == IW'(ENTRIES - 1));
	assign finish = (state_q == ST_SCAN) && pv_s1 && (hit || last);
	assign wr_en = finish && hit && ((act_q == ACT_ADD) || (act_q == ACT_DEL));
	assign wr_set = (act_q == ACT_ADD);

	// Request registers; no reset needed on payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action_t'(action);
			lo_q <= offset;
			hi_q <= {1'b0, offset} + {{(END_W - LEN_W){1'b0}}, length};
		end
		ridx_s1 <= idx_q[IW-1:0];
	end

	// Sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			pv_s1 <= 1'b0;
			locked_q <= 1'b0;
			status_q <= STS_OK;
		end else begin
			pv_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (action_t'(action) == ACT_NONE) begin
							locked_q <= 1'b0;
							status_q <= STS_OK;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						idx_q <= idx_q + CW'(1);
					end
					if (finish) begin
						locked_q <= (act_q == ACT_QUERY) && hit;
						case (act_q)
							ACT_ADD: status_q <= hit ? STS_OK : STS_FULL;
							ACT_DEL: status_q <= hit ? STS_OK : STS_NOT_FOUND;
							default: status_q <= STS_OK;
						endcase
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// An accepted request always leaves the idle state.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted request did not start work");

	// The scan index never runs past the table.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CW'(ENTRIES))
		else $error("scan index out of range");

	// Table full is reported only for an add.
	a_full_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status_q == STS_FULL)) |-> (act_q == ACT_ADD))
		else $error("table full on a non-add request");

	// Locked is reported only for a query.
	a_locked_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && locked_q) |-> (act_q == ACT_QUERY))
		else $error("locked set on a non-query request");

	// The store is written only on the cycle that ends a scan.
	a_write_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (state_q == ST_DONE))
		else $error("entry written outside the end of a scan");

endmodule

// ===== src/rlt_mem.sv =====
// Entry store: start and end memories with registered read, and valid flags.
module rlt_mem #(
	parameter int ENTRIES = rlt_pkg::ENTRIES_DEF,
	parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [IW-1:0]            rd_addr,
	input  logic                     wr_en,
	input  logic                     wr_set,
	input  logic [IW-1:0]            wr_addr,
	input  logic [rlt_pkg::OFS_W-1:0] wr_start,
	input  logic [rlt_pkg::END_W-1:0] wr_end,
	output logic                     rd_valid_q,
	output logic [rlt_pkg::OFS_W-1:0] rd_start_q,
	output logic [rlt_pkg::END_W-1:0] rd_end_q
);
	import rlt_pkg::*;

	logic [OFS_W-1:0] start_mem [ENTRIES];
	logic [END_W-1:0] end_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	// Range memories: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en && wr_set) begin
			start_mem[wr_addr] <= wr_start;
			end_mem[wr_addr] <= wr_end;
		end
		if (rd_en) begin
			rd_start_q <= start_mem[rd_addr];
			rd_end_q <= end_mem[rd_addr];
		end
	end

	// Valid flags are cleared at reset; an add sets one and a delete clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= wr_set;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

endmodule

// ===== src/rlt_cmp.sv =====
// Shared compare unit: checks one stored entry against the request range.
module rlt_cmp (
	input  logic [rlt_pkg::OFS_W-1:0] ent_start,
	input  logic [rlt_pkg::END_W-1:0] ent_end,
	input  logic [rlt_pkg::OFS_W-1:0] lo,
	input  logic [rlt_pkg::END_W-1:0] hi,
	output rlt_pkg::cmp_res_t         res
);
	import rlt_pkg::*;

	logic [END_W-1:0] start_x;
	logic [END_W-1:0] lo_x;

	assign start_x = {1'b0, ent_start};
	assign lo_x = {1'b0, lo};

	// Exact match for delete, half-open overlap for query.
	assign res.exact = (ent_start == lo) && (ent_end == hi);
	assign res.overlap = (start_x < hi) && (ent_end > lo_x);

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the range lock table: paced stimulus, scoreboard and run control.
`timescale 1ns / 1ps

module tb;
	import rlt_pkg::*;

	localparam int TABLE_SLOTS = ENTRIES_DEF;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_WORDS = 170;
	localparam bit [OFS_W-1:0] TOP_OFS = '1;
	localparam bit [LEN_W-1:0] MAX_LEN = '1;

	// One expected result word.
	typedef struct packed {
		logic    locked;
		status_t status;
	} lock_result_t;

	// Scoreboard: keeps its own copy of the lock table and the results still owed.
	class lock_scoreboard;
		bit             held [TABLE_SLOTS];
		bit [OFS_W-1:0] held_lo [TABLE_SLOTS];
		bit [END_W-1:0] held_hi [TABLE_SLOTS];
		lock_result_t   pending_outcomes [$];
		int             mismatches;
		int             requests;
		int             results;
		int             full_seen;
		int             missing_seen;
		int             hits_seen;

		// Applies one request to the table copy and returns the result it gives.
		function lock_result_t lock_outcome(action_t act, bit [OFS_W-1:0] lo,
				bit [LEN_W-1:0] len);
			bit [END_W-1:0] hi;
			lock_result_t   res;
			// The end is formed one bit wider than the offset, so it never wraps.
			hi = {1'b0, lo} + END_W'(len);
			res.locked = 1'b0;
			res.status = STS_OK;
			case (act)
			ACT_ADD: begin
				res.status = STS_FULL;
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (!held[i]) begin
						held[i] = 1'b1;
						held_lo[i] = lo;
						held_hi[i] = hi;
						res.status = STS_OK;
						break;
					end
				end
			end
			ACT_DEL: begin
				res.status = STS_NOT_FOUND;
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (held[i] && held_lo[i] == lo && held_hi[i] == hi) begin
						held[i] = 1'b0;
						res.status = STS_OK;
						break;
					end
				end
			end
			ACT_QUERY: begin
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (held[i] && {1'b0, held_lo[i]} < hi && held_hi[i] > {1'b0, lo}) begin
						res.locked = 1'b1;
						break;
					end
				end
			end
			default: begin
			end
			endcase
			return res;
		endfunction

		function void note_request(action_t act, bit [OFS_W-1:0] lo, bit [LEN_W-1:0] len);
			pending_outcomes.push_back(lock_outcome(act, lo, len));
			requests++;
		endfunction

		task report_mismatch(string what);
			if (mismatches < 50)
				$display("mismatch at %0t: %s", $time, what);
			mismatches++;
		endtask

		// Compares one accepted result word with the oldest expectation.
		task check_response(logic got_locked, logic [STS_W-1:0] got_status);
			lock_result_t want;
			results++;
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("result with none expected, locked=%0b code=%0d",
					got_locked, got_status));
				return;
			end
			want = pending_outcomes.pop_front();
			if (got_locked !== want.locked)
				report_mismatch($sformatf("locked got %0b want %0b", got_locked, want.locked));
			if (got_status !== want.status)
				report_mismatch($sformatf("status code got %0d want %0d", got_status,
					want.status));
			if (want.status == STS_FULL)
				full_seen++;
			if (want.status == STS_NOT_FOUND)
				missing_seen++;
			if (want.locked)
				hits_seen++;
		endtask

		task flush_leftovers();
			while (pending_outcomes.size() != 0) begin
				void'(pending_outcomes.pop_front());
				report_mismatch("expected result never arrived");
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [ACT_W-1:0]   action = '0;
	logic [OFS_W-1:0]   offset = '0;
	logic [LEN_W-1:0]   length = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic               locked;
	logic [STS_W-1:0]   status;

	int                 idle_pct = 0;
	int                 stall_pct = 0;
	logic               hold_rsp = 1'b0;
	bit [OFS_W-1:0]     kept_lo [$];
	bit [LEN_W-1:0]     kept_len [$];

	lock_scoreboard     board = new();

	range_lock_table #(
		.ENTRIES(TABLE_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.offset(offset),
		.length(length),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.locked(locked),
		.status(status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Response side: random stalls plus an optional long hold.
	always @(posedge clk) begin
		rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
	end

	// Watch both channels; every accepted word goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				board.note_request(action_t'(action), offset, length);
			if (rsp_valid && !rsp_stall)
				board.check_response(locked, status);
		end
	end

	// Hard limit on the run time.
	initial begin
		#(5_000_000);
		$display("status: fail");
		$finish;
	end

	function automatic bit [OFS_W-1:0] rand_offset();
		case ($urandom_range(9))
		0, 1, 2, 3, 4, 5: return OFS_W'($urandom_range(0, 255));
		6, 7: return TOP_OFS - OFS_W'($urandom_range(0, 255));
		default: return OFS_W'({$urandom, $urandom});
		endcase
	endfunction

	function automatic bit [LEN_W-1:0] rand_length();
		case ($urandom_range(9))
		0: return '0;
		1, 2, 3, 4, 5, 6: return LEN_W'($urandom_range(1, 32));
		7: return MAX_LEN - $urandom_range(0, 3);
		default: return LEN_W'($urandom);
		endcase
	endfunction

	// Drops one copy of a range from the list of ranges believed held.
	function automatic void forget_range(bit [OFS_W-1:0] lo, bit [LEN_W-1:0] len);
		for (int i = 0; i < kept_lo.size(); i++) begin
			if (kept_lo[i] == lo && kept_len[i] == len) begin
				kept_lo.delete(i);
				kept_len.delete(i);
				return;
			end
		end
	endfunction

	// Offers one request word until it is taken, then maybe goes idle for a while.
	task automatic send_word(action_t act, bit [OFS_W-1:0] lo, bit [LEN_W-1:0] len);
		req_valid <= 1'b1;
		action <= act;
		offset <= lo;
		length <= len;
		do @(posedge clk); while (req_stall);
		if (act == ACT_ADD && kept_lo.size() < TABLE_SLOTS) begin
			kept_lo.push_back(lo);
			kept_len.push_back(len);
		end
		if (act == ACT_DEL)
			forget_range(lo, len);
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// One random request; deletes and queries are mostly built around ranges that are likely held.
	task automatic random_word();
		int             pick;
		int             k;
		bit [OFS_W-1:0] lo;
		bit [LEN_W-1:0] len;
		bit [END_W-1:0] hi;
		pick = $urandom_range(99);
		lo = rand_offset();
		len = rand_length();
		if (pick < 3) begin
			send_word(ACT_NONE, lo, len);
		end else if (pick < 40) begin
			send_word(ACT_ADD, lo, len);
		end else if (pick < 68) begin
			// Deletes mostly hit a held range exactly; some miss by one byte.
			if (kept_lo.size() != 0 && $urandom_range(9) < 8) begin
				k = $urandom_range(kept_lo.size() - 1);
				lo = kept_lo[k];
				len = kept_len[k];
				if ($urandom_range(9) == 0)
					len = len + LEN_W'(1);
			end
			send_word(ACT_DEL, lo, len);
		end else begin
			// Queries probe the edges of a held range.
			if (kept_lo.size() != 0 && $urandom_range(3) != 0) begin
				k = $urandom_range(kept_lo.size() - 1);
				hi = {1'b0, kept_lo[k]} + END_W'(kept_len[k]);
				case ($urandom_range(4))
				0: lo = kept_lo[k] - OFS_W'($urandom_range(0, 2));
				1: lo = kept_lo[k] + OFS_W'($urandom_range(0, 2));
				2: lo = hi[OFS_W-1:0] - OFS_W'(1);
				3: lo = hi[OFS_W-1:0];
				default: lo = rand_offset();
				endcase
				case ($urandom_range(3))
				0: len = '0;
				1: len = LEN_W'($urandom_range(1, 2));
				2: len = kept_len[k];
				default: len = LEN_W'($urandom_range(0, 40));
				endcase
			end
			send_word(ACT_QUERY, lo, len);
		end
	endtask

	// Waits until every expected result word has been taken.
	task automatic wait_drained();
		@(posedge clk);
		while (board.pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic hold_responses(int cycles);
		hold_rsp <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_rsp <= 1'b0;
	endtask

	// Main sequence: reset, directed cases, then four paced random phases.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: query finds nothing, delete finds nothing.
		send_word(ACT_QUERY, '0, MAX_LEN);
		send_word(ACT_DEL, '0, 32'd10);
		// Duplicates, the topmost range and an empty range.
		send_word(ACT_ADD, '0, 32'd10);
		send_word(ACT_ADD, '0, 32'd10);
		send_word(ACT_ADD, TOP_OFS, MAX_LEN);
		send_word(ACT_ADD, 48'd100, '0);
		// A zero-length query and the boundaries of half-open ranges.
		send_word(ACT_QUERY, 48'd5, '0);
		send_word(ACT_QUERY, 48'd10, 32'd5);
		send_word(ACT_QUERY, 48'd99, 32'd2);
		send_word(ACT_QUERY, 48'd100, 32'd1);
		// Fill the table, then one add too many.
		for (int i = 0; i < 13; i++)
			send_word(ACT_ADD, 48'h1000 + OFS_W'(i * 64), 32'd16);
		send_word(ACT_NONE, TOP_OFS, MAX_LEN);
		send_word(ACT_DEL, '0, 32'd10);
		send_word(ACT_DEL, '0, 32'd9);
		req_valid <= 1'b0;
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
			0: begin
				idle_pct = 0;
				stall_pct <= 0;
			end
			1: begin
				idle_pct = 53;
				stall_pct <= 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct <= 53;
			end
			default: begin
				idle_pct = 29;
				stall_pct <= 29;
			end
			endcase
			// In the first phase the response side holds off while requests keep coming.
			if (p == 0) begin
				fork
					hold_responses(HOLD_CYCLES);
				join_none
			end
			repeat (PHASE_WORDS) random_word();
			req_valid <= 1'b0;
			wait_drained();
		end

		repeat (TABLE_SLOTS + 8) @(posedge clk);
		board.flush_leftovers();
		$display("summary: %0d requests and %0d results; %0d adds hit a full table,",
			board.requests, board.results, board.full_seen);
		$display("summary: %0d deletes found no match, %0d queries overlapped; %0d-cycle hold",
			board.missing_seen, board.hits_seen, HOLD_CYCLES);
		if (board.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
src/rlt_pkg.sv
src/rlt_mem.sv
src/rlt_cmp.sv
src/range_lock_table.sv
tb/sv/tb.sv
